[rtl/wind_speed_average_and_gust_defines.svh]
// Assertion macros shared by the wind speed average and gust RTL.
// Included by the top level; relies on nothing else.
`ifndef WIND_SPEED_AVERAGE_AND_GUST_DEFINES_SVH
`define WIND_SPEED_AVERAGE_AND_GUST_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define WSAG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsag assertion failed");

// Next-cycle implication, disabled during reset
`define WSAG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsag assertion failed");

`endif

[rtl/wsag_pkg.sv]
// Package for the wind speed average and gust block: widths, register
// indexes, state types and shared structs. Depends on nothing.
`timescale 1ns / 1ps

package wsag_pkg;

    localparam int PULSE_W    = 10;
    localparam int SPEED_W    = 16;
    localparam int GL_W       = 6;
    localparam int SCALE_W    = 16;
    localparam int GATE_SUM_W = 16;
    localparam int RPT_SUM_W  = 32;
    localparam int RPT_SEC_W  = 16;
    localparam int DIV_W      = 20;
    localparam int PROD_W     = 48;
    localparam int REM_W      = 36;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GL_W-1:0]    GL_RESET    = 6'd3;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd667;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 1'd1;

    // Input operation codes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_AVG,
        TOP_GUST,
        TOP_HOLD
    } wsag_top_state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHK,
        MD_DIV
    } wsag_md_state_t;

    // Report totals as seen by the sequencer (partial gate folded in)
    typedef struct packed {
        logic [RPT_SUM_W-1:0]  pulses;
        logic [RPT_SEC_W-1:0]  secs;
        logic [GATE_SUM_W-1:0] maxg;
    } wsag_view_t;

    // Request to the serial multiply/divide unit
    typedef struct packed {
        logic                 start;
        logic [RPT_SUM_W-1:0] mcand;
        logic [SCALE_W-1:0]   mplier;
        logic [DIV_W-1:0]     divisor;
    } wsag_md_req_t;

    // Status from the serial multiply/divide unit
    typedef struct packed {
        logic               busy;
        logic [SPEED_W-1:0] quot;
    } wsag_md_stat_t;

    // 10 * x by shift and add
    function automatic logic [DIV_W-1:0] times_ten(input logic [RPT_SEC_W-1:0] x);
        logic [DIV_W-1:0] xe;
        xe = {{(DIV_W-RPT_SEC_W){1'b0}}, x};
        return (xe << 3) + (xe << 1);
    endfunction

endpackage

[rtl/wsag_if.sv]
// Channel interfaces for the wind speed average and gust block:
// input items, result items and configuration writes. Depends on wsag_pkg.
`timescale 1ns / 1ps

interface wsag_sample_if import wsag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               op;
    logic [PULSE_W-1:0] pulses_this_second;

    modport source (output valid, output op, output pulses_this_second, input ready);
    modport sink   (input valid, input op, input pulses_this_second, output ready);
endinterface

interface wsag_result_if import wsag_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [SPEED_W-1:0] avg_speed_cms;
    logic [SPEED_W-1:0] gust_speed_cms;

    modport source (output valid, output avg_speed_cms, output gust_speed_cms, input ready);
    modport sink   (input valid, input avg_speed_cms, input gust_speed_cms, output ready);
endinterface

interface wsag_cfg_if import wsag_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/wind_speed_average_and_gust.sv]
// Wind speed average and gust, top level.
// Channels: sample (input items: op, pulses_this_second), result (avg and
// gust speed in cm/s), cfg (register writes: index 0 gate_length, index 1
// speed_scale). Each channel moves a transaction on valid && ready.
// A tick (op 0) is absorbed and gives no result. A report
// (op 1) snapshots and clears the totals, then runs the shared serial
// multiply/divide unit twice, each run a multiply, a range check and a
// divide; the divide is skipped when the quotient saturates or the
// divisor is zero. Sample ready returns in the same cycle as the result
// turns valid, so a report holds off the input until the result is valid.
// The result sits in an output register until taken; while it waits, ticks
// are still accepted, and a following report computes but holds its result
// until the register frees. Reset clears all totals, loads gate_length 3
// and speed_scale 667, and leaves the result channel empty.
// cfg is always ready.
// Depends on wsag_pkg, wsag_if, wsag_accum, wsag_muldiv and the defines header.
`timescale 1ns / 1ps
`include "wind_speed_average_and_gust_defines.svh"

module wind_speed_average_and_gust import wsag_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wsag_sample_if.sink   sample,
    wsag_result_if.source result,
    wsag_cfg_if.sink      cfg
);

    logic [GL_W-1:0]    gate_length_reg;
    logic [SCALE_W-1:0] speed_scale_reg;

    wsag_top_state_t    state_reg, state_next;
    logic [GATE_SUM_W-1:0] maxg_reg, maxg_next;
    logic [SPEED_W-1:0] avg_reg, avg_next;
    logic               out_valid_reg, out_valid_next;
    logic [SPEED_W-1:0] out_avg_reg, out_avg_next;
    logic [SPEED_W-1:0] out_gust_reg, out_gust_next;

    logic               accept;
    logic               is_tick;
    logic               is_report;
    logic               out_free;
    wsag_view_t         view;
    wsag_md_req_t       md_req;
    wsag_md_stat_t      md_stat;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_length_reg <= GL_RESET;
            speed_scale_reg <= SCALE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_GATE_LENGTH: gate_length_reg <= cfg.data[GL_W-1:0];
                REG_SPEED_SCALE: speed_scale_reg <= cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake
    assign sample.ready = (state_reg == TOP_IDLE);
    assign accept       = sample.valid && sample.ready;
    assign is_tick      = accept && (sample.op == OP_TICK);
    assign is_report    = accept && (sample.op == OP_REPORT);
    assign out_free     = !out_valid_reg || result.ready;

    wsag_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (is_tick),
        .pulses      (sample.pulses_this_second),
        .clear       (is_report),
        .gate_length (gate_length_reg),
        .view        (view)
    );

    wsag_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .stat  (md_stat)
    );

    // Report sequencer
    always_comb
    begin
        state_next     = state_reg;
        maxg_next      = maxg_reg;
        avg_next       = avg_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_avg_next   = out_avg_reg;
        out_gust_next  = out_gust_reg;
        md_req.start   = 1'b0;
        md_req.mcand   = view.pulses;
        md_req.mplier  = speed_scale_reg;
        md_req.divisor = times_ten(view.secs);
        case (state_reg)
            TOP_IDLE:
            begin
                if (is_report)
                begin
                    md_req.start = 1'b1;
                    maxg_next    = view.maxg;
                    state_next   = TOP_AVG;
                end
            end
            TOP_AVG:
            begin
                md_req.mcand   = {{(RPT_SUM_W-GATE_SUM_W){1'b0}}, maxg_reg};
                md_req.divisor = times_ten({{(RPT_SEC_W-GL_W){1'b0}}, gate_length_reg});
                if (!md_stat.busy)
                begin
                    avg_next     = md_stat.quot;
                    md_req.start = 1'b1;
                    state_next   = TOP_GUST;
                end
            end
            TOP_GUST, TOP_HOLD:
            begin
                if (!md_stat.busy)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_avg_next   = avg_reg;
                        out_gust_next  = md_stat.quot;
                        state_next     = TOP_IDLE;
                    end
                    else
                    begin
                        state_next = TOP_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        maxg_reg     <= maxg_next;
        avg_reg      <= avg_next;
        out_avg_reg  <= out_avg_next;
        out_gust_reg <= out_gust_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.avg_speed_cms  = out_avg_reg;
    assign result.gust_speed_cms = out_gust_reg;

    // Checks
    `WSAG_ASSERT_IMP(a_idle_unit_free, clk, rst_n, state_reg == TOP_IDLE, !md_stat.busy)
    `WSAG_ASSERT_NEXT(a_report_clears, clk, rst_n, is_report, view.pulses == '0 && view.secs == '0 && view.maxg == '0)
    `WSAG_ASSERT_NEXT(a_report_starts_unit, clk, rst_n, is_report, md_stat.busy && state_reg == TOP_AVG)

endmodule

[rtl/wsag_accum.sv]
// Per-second pulse accumulation: gate total, report totals and largest
// gate total, with saturation. Depends on wsag_pkg.
`timescale 1ns / 1ps

module wsag_accum import wsag_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic [PULSE_W-1:0] pulses,
    input  logic               clear,
    input  logic [GL_W-1:0]    gate_length,
    output wsag_view_t         view
);

    logic [GATE_SUM_W-1:0] gps_reg, gps_next;
    logic [GL_W-1:0]       gsd_reg, gsd_next;
    logic [RPT_SUM_W-1:0]  rps_reg, rps_next;
    logic [RPT_SEC_W-1:0]  rss_reg, rss_next;
    logic [GATE_SUM_W-1:0] mgs_reg, mgs_next;

    logic [GATE_SUM_W:0]   gsum_ext;
    logic [GATE_SUM_W-1:0] gsum_sat;
    logic [GL_W-1:0]       gsec_inc;
    logic                  gate_end;
    logic [RPT_SUM_W:0]    rps_ext;
    logic [RPT_SEC_W:0]    rss_ext;
    logic [RPT_SUM_W:0]    vp_ext;
    logic [RPT_SEC_W:0]    vs_ext;

    // Tick arithmetic
    always_comb
    begin
        gsum_ext = {1'b0, gps_reg} + {{(GATE_SUM_W+1-PULSE_W){1'b0}}, pulses};
        gsum_sat = gsum_ext[GATE_SUM_W] ? '1 : gsum_ext[GATE_SUM_W-1:0];
        gsec_inc = gsd_reg + {{(GL_W-1){1'b0}}, 1'b1};
        gate_end = (gsec_inc >= gate_length);
        rps_ext  = {1'b0, rps_reg} + {{(RPT_SUM_W+1-GATE_SUM_W){1'b0}}, gsum_sat};
        rss_ext  = {1'b0, rss_reg} + {{(RPT_SEC_W+1-GL_W){1'b0}}, gsec_inc};
    end

    // Next state: clear on report, fold gate on gate end
    always_comb
    begin
        gps_next = gps_reg;
        gsd_next = gsd_reg;
        rps_next = rps_reg;
        rss_next = rss_reg;
        mgs_next = mgs_reg;
        if (clear)
        begin
            gps_next = '0;
            gsd_next = '0;
            rps_next = '0;
            rss_next = '0;
            mgs_next = '0;
        end
        else if (tick)
        begin
            if (gate_end)
            begin
                if (gsum_sat > mgs_reg)
                    mgs_next = gsum_sat;
                rps_next = rps_ext[RPT_SUM_W] ? '1 : rps_ext[RPT_SUM_W-1:0];
                rss_next = rss_ext[RPT_SEC_W] ? '1 : rss_ext[RPT_SEC_W-1:0];
                gps_next = '0;
                gsd_next = '0;
            end
            else
            begin
                gps_next = gsum_sat;
                gsd_next = gsec_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gps_reg <= '0;
            gsd_reg <= '0;
            rps_reg <= '0;
            rss_reg <= '0;
            mgs_reg <= '0;
        end
        else
        begin
            gps_reg <= gps_next;
            gsd_reg <= gsd_next;
            rps_reg <= rps_next;
            rss_reg <= rss_next;
            mgs_reg <= mgs_next;
        end
    end

    // Report view with the unfinished gate folded in
    always_comb
    begin
        vp_ext      = {1'b0, rps_reg} + {{(RPT_SUM_W+1-GATE_SUM_W){1'b0}}, gps_reg};
        vs_ext      = {1'b0, rss_reg} + {{(RPT_SEC_W+1-GL_W){1'b0}}, gsd_reg};
        view.pulses = vp_ext[RPT_SUM_W] ? '1 : vp_ext[RPT_SUM_W-1:0];
        view.secs   = vs_ext[RPT_SEC_W] ? '1 : vs_ext[RPT_SEC_W-1:0];
        view.maxg   = (gps_reg > mgs_reg) ? gps_reg : mgs_reg;
    end

endmodule

[rtl/wsag_muldiv.sv]
// Serial multiply then divide: q = min(mcand * mplier / divisor, 65535),
// 0 for a zero divisor. One multiplier bit, then one quotient bit, per cycle.
// Depends on wsag_pkg.
`timescale 1ns / 1ps

module wsag_muldiv import wsag_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  wsag_md_req_t  req,
    output wsag_md_stat_t stat
);

    wsag_md_state_t       state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [RPT_SUM_W-1:0] a_reg, a_next;
    logic [SCALE_W-1:0]   b_reg, b_next;
    logic [DIV_W-1:0]     d_reg, d_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [REM_W-1:0]     dsh_reg, dsh_next;
    logic [SPEED_W-1:0]   q_reg, q_next;

    logic [PROD_W-1:0]    addend;
    logic [PROD_W-1:0]    sat_limit;
    logic                 fits;
    logic [REM_W-1:0]     rem_diff;

    always_comb
    begin
        addend    = b_reg[SCALE_W-1] ? {{(PROD_W-RPT_SUM_W){1'b0}}, a_reg} : '0;
        sat_limit = {{(PROD_W-DIV_W-SPEED_W){1'b0}}, d_reg, {SPEED_W{1'b0}}};
        fits      = (acc_reg[REM_W-1:0] >= dsh_reg);
        rem_diff  = acc_reg[REM_W-1:0] - dsh_reg;
    end

    // Sequencer: multiply, range check, divide
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        dsh_next   = dsh_reg;
        q_next     = q_reg;
        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.mcand;
                    b_next     = req.mplier;
                    d_next     = req.divisor;
                    acc_next   = '0;
                    cnt_next   = '1;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                // MSB-first shift and add
                acc_next = {acc_reg[PROD_W-2:0], 1'b0} + addend;
                b_next   = {b_reg[SCALE_W-2:0], 1'b0};
                cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                if (cnt_reg == '0)
                    state_next = MD_CHK;
            end
            MD_CHK:
            begin
                if (d_reg == '0)
                begin
                    q_next     = '0;
                    state_next = MD_IDLE;
                end
                else if (acc_reg >= sat_limit)
                begin
                    q_next     = '1;
                    state_next = MD_IDLE;
                end
                else
                begin
                    // quotient fits in 16 bits; remainder fits in REM_W
                    q_next     = '0;
                    dsh_next   = {1'b0, d_reg, {(SPEED_W-1){1'b0}}};
                    cnt_next   = '1;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (fits)
                    acc_next = {acc_reg[PROD_W-1:REM_W], rem_diff};
                q_next   = {q_reg[SPEED_W-2:0], fits};
                dsh_next = {1'b0, dsh_reg[REM_W-1:1]};
                cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
                if (cnt_reg == '0)
                    state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign stat.busy = (state_reg != MD_IDLE);
    assign stat.quot = q_reg;

endmodule

[bench/wind_speed_average_and_gust_tb.sv]
// Self-checking bench for wind_speed_average_and_gust: a directed table, then random
// tick/report sequences over several register settings, scored against a local predictor.
// Depends on wsag_pkg, the channel interfaces in wsag_if and the top level RTL.
`timescale 1ns / 1ps

module wind_speed_average_and_gust_tb;
    import wsag_pkg::*;

    localparam int SETTLE_CYCLES = 100;   // outlasts a full report computation
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transaction on any channel
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 85;
    localparam int LONG_TICKS    = 60;    // gapless tick stream before the last report

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          value;    // pulse count or register data
        logic                 pinned;   // expected result typed in below
        logic [SPEED_W-1:0]   pin_avg;
        logic [SPEED_W-1:0]   pin_gust;
    } stim_row_t;

    typedef struct packed {
        logic [SPEED_W-1:0] avg;
        logic [SPEED_W-1:0] gust;
    } speed_pair_t;

    logic clk;
    logic rst_n;

    wsag_sample_if sample_ch ();
    wsag_result_if result_ch ();
    wsag_cfg_if    cfg_ch ();

    wind_speed_average_and_gust dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state and register copies
    logic [GL_W-1:0]       cf_gate_len = GL_RESET;
    logic [SCALE_W-1:0]    cf_scale    = SCALE_RESET;
    logic [GATE_SUM_W-1:0] st_gate_sum      = '0;
    logic [GL_W-1:0]       st_gate_secs     = '0;
    logic [RPT_SUM_W-1:0]  st_period_pulses = '0;
    logic [RPT_SEC_W-1:0]  st_period_secs   = '0;
    logic [GATE_SUM_W-1:0] st_peak_gate     = '0;

    speed_pair_t pending_speeds[$];

    int fail_count    = 0;
    int items_sent    = 0;
    int reports_sent  = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    int stall_left    = 0;
    int stall_mode    = 0;
    bit long_haul     = 1'b0;

    stim_row_t dir_rows[$];

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [SPEED_W-1:0] got,
                                   input logic [SPEED_W-1:0] want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // pulses * scale / (10 * seconds), 0 for no seconds, saturated to 16 bits
    function automatic logic [SPEED_W-1:0] to_cms(input logic [RPT_SUM_W-1:0] pulses,
                                                 input logic [RPT_SEC_W-1:0] secs);
        logic [47:0] prod;
        logic [47:0] quo;
        if (secs == '0)
            return '0;
        prod = pulses * cf_scale;
        quo  = prod / (48'd10 * secs);
        return (quo > 48'hFFFF) ? 16'hFFFF : quo[15:0];
    endfunction

    // Advance the station model by one item; a report yields a speed pair
    task automatic advance_station(input logic op, input logic [PULSE_W-1:0] p,
                                   output bit has_res, output speed_pair_t res);
        logic [16:0]          gsum;
        logic [16:0]          ssum;
        logic [32:0]          psum;
        logic [RPT_SUM_W-1:0] pulses;
        logic [RPT_SEC_W-1:0] secs;
        logic [GATE_SUM_W-1:0] peak;
        has_res = 1'b0;
        res     = '0;
        if (op == OP_TICK)
        begin
            gsum = {1'b0, st_gate_sum} + p;
            st_gate_sum  = gsum[16] ? 16'hFFFF : gsum[15:0];
            st_gate_secs = st_gate_secs + 1'b1;
            // gate end, also when the length was lowered below the count
            if (st_gate_secs >= cf_gate_len)
            begin
                if (st_gate_sum > st_peak_gate)
                    st_peak_gate = st_gate_sum;
                psum = {1'b0, st_period_pulses} + st_gate_sum;
                st_period_pulses = psum[32] ? '1 : psum[31:0];
                ssum = {1'b0, st_period_secs} + st_gate_secs;
                st_period_secs = ssum[16] ? '1 : ssum[15:0];
                st_gate_sum  = '0;
                st_gate_secs = '0;
            end
        end
        else
        begin
            // fold in the unfinished gate
            psum   = {1'b0, st_period_pulses} + st_gate_sum;
            pulses = psum[32] ? '1 : psum[31:0];
            ssum   = {1'b0, st_period_secs} + st_gate_secs;
            secs   = ssum[16] ? '1 : ssum[15:0];
            peak   = (st_gate_sum > st_peak_gate) ? st_gate_sum : st_peak_gate;
            res.avg  = to_cms(pulses, secs);
            res.gust = to_cms(peak, cf_gate_len);
            has_res  = 1'b1;
            st_gate_sum      = '0;
            st_gate_secs     = '0;
            st_period_pulses = '0;
            st_period_secs   = '0;
            st_peak_gate     = '0;
        end
    endtask

    // One sample transaction; bursts with random gaps unless in the long haul
    task automatic send_item(input logic op, input logic [PULSE_W-1:0] p, input logic pinned,
                             input logic [SPEED_W-1:0] pin_avg,
                             input logic [SPEED_W-1:0] pin_gust);
        bit          has_res;
        speed_pair_t res;
        if (burst_left == 0)
        begin
            if (!long_haul)
            begin
                sample_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        sample_ch.valid              <= 1'b1;
        sample_ch.op                 <= op;
        sample_ch.pulses_this_second <= p;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        items_sent++;
        advance_station(op, p, has_res, res);
        if (has_res)
        begin
            reports_sent++;
            if (pinned)
                pending_speeds.push_back({pin_avg, pin_gust});
            else
                pending_speeds.push_back(res);
        end
    endtask

    // Register write, only once the block has gone idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] wdata);
        sample_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= wdata;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_GATE_LENGTH)
            cf_gate_len = wdata[GL_W-1:0];
        else
            cf_scale = wdata[SCALE_W-1:0];
        cfg_writes++;
    endtask

    // Result receiver stall pattern: steady stretches, stalls and choppy cycles
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 9);
                if (stall_mode < 3)
                begin
                    result_ch.ready <= 1'b1;
                    stall_left = $urandom_range(20, 150);
                end
                else if (stall_mode < 6)
                begin
                    result_ch.ready <= 1'b0;
                    stall_left = $urandom_range(1, 30);
                end
                else
                begin
                    result_ch.ready <= ($urandom_range(0, 1) == 1);
                    stall_left = 1;
                end
            end
            else
                stall_left--;
        end
    end

    // Result scoreboard
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (pending_speeds.size() == 0)
                report_mismatch("result with nothing pending, avg", result_ch.avg_speed_cms, '0);
            else
            begin
                speed_pair_t want;
                want = pending_speeds.pop_front();
                if (result_ch.avg_speed_cms !== want.avg)
                    report_mismatch("avg_speed_cms", result_ch.avg_speed_cms, want.avg);
                if (result_ch.gust_speed_cms !== want.gust)
                    report_mismatch("gust_speed_cms", result_ch.gust_speed_cms, want.gust);
            end
        end
    end

    // Watchdog on stretches with no transaction at all
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles, %0d results pending",
                     $realtime, quiet_cycles, pending_speeds.size());
            $display("wind_speed_average_and_gust verification failed");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        logic [GL_W-1:0]    gl;
        logic [SCALE_W-1:0] sc;
        logic [PULSE_W-1:0] p;
        int                 n_ticks;
        int                 phase_items;
        int                 sel;

        rst_n                        = 1'b0;
        sample_ch.valid              = 1'b0;
        sample_ch.op                 = OP_TICK;
        sample_ch.pulses_this_second = '0;
        cfg_ch.valid                 = 1'b0;
        cfg_ch.index                 = REG_GATE_LENGTH;
        cfg_ch.data                  = '0;

        dir_rows = '{
            // empty period straight after reset
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd0,     16'd0},
            // one full gate at top pulse rate saturates both speeds
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd65535, 16'd65535},
            // calm second
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd0,    1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd0,     16'd0},
            // report over a partial gate
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd10,   1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd20,   1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b0, 16'd0,     16'd0},
            // gate length zero, upper data bits set and dropped
            '{ROW_CFG,  OP_TICK,   REG_GATE_LENGTH, 16'hFFC0, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd5,    1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b0, 16'd0,     16'd0},
            // zero scale
            '{ROW_CFG,  OP_TICK,   REG_GATE_LENGTH, 16'd60,   1'b0, 16'd0,     16'd0},
            '{ROW_CFG,  OP_TICK,   REG_SPEED_SCALE, 16'd0,    1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd512,  1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd0,     16'd0},
            // widest gate, full scale: large products saturate
            '{ROW_CFG,  OP_TICK,   REG_GATE_LENGTH, 16'd63,   1'b0, 16'd0,     16'd0},
            '{ROW_CFG,  OP_TICK,   REG_SPEED_SCALE, 16'hFFFF, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd1023, 1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd65535, 16'd65535},
            // gate length lowered under the running second count
            '{ROW_CFG,  OP_TICK,   REG_GATE_LENGTH, 16'd5,    1'b0, 16'd0,     16'd0},
            '{ROW_CFG,  OP_TICK,   REG_SPEED_SCALE, 16'd667,  1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd341,  1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd682,  1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd100,  1'b0, 16'd0,     16'd0},
            '{ROW_CFG,  OP_TICK,   REG_GATE_LENGTH, 16'd2,    1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_TICK,   REG_GATE_LENGTH, 16'd7,    1'b0, 16'd0,     16'd0},
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b0, 16'd0,     16'd0},
            // back-to-back report on cleared totals
            '{ROW_ITEM, OP_REPORT, REG_GATE_LENGTH, 16'd0,    1'b1, 16'd0,     16'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_reg(dir_rows[i].idx, dir_rows[i].value);
            else
                send_item(dir_rows[i].op, dir_rows[i].value[PULSE_W-1:0], dir_rows[i].pinned,
                          dir_rows[i].pin_avg, dir_rows[i].pin_gust);
        end

        // Random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       begin gl = 6'd1;  sc = 16'hFFFF; end
                1:       begin gl = 6'd60; sc = 16'($urandom_range(0, 65535)); end
                2:       begin gl = 6'd63; sc = SCALE_RESET; end
                3:       begin gl = 6'd0;  sc = 16'($urandom_range(0, 65535)); end
                default:
                begin
                    gl = 6'($urandom_range(1, 12));
                    sc = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 2000));
                end
            endcase
            write_reg(REG_GATE_LENGTH, {10'($urandom_range(0, 1023)), gl});
            write_reg(REG_SPEED_SCALE, sc);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                n_ticks = $urandom_range(0, (gl < 8) ? 3 * gl + 3 : 2 * gl + 5);
                for (int t = 0; t < n_ticks; t++)
                begin
                    sel = $urandom_range(0, 9);
                    case (sel)
                        0:       p = '0;
                        1:       p = '1;
                        2:       p = 10'($urandom_range(0, 15));
                        default: p = 10'($urandom_range(0, 1023));
                    endcase
                    send_item(OP_TICK, p, 1'b0, '0, '0);
                end
                // reports carry random junk in the unused pulse field
                send_item(OP_REPORT, 10'($urandom_range(0, 1023)), 1'b0, '0, '0);
                phase_items += n_ticks + 1;
            end
        end

        // Long haul: ticks back to back with no gaps, closed by one report
        write_reg(REG_GATE_LENGTH, 16'd1);
        write_reg(REG_SPEED_SCALE, 16'd100);
        long_haul = 1'b1;
        for (int t = 0; t < LONG_TICKS; t++)
            send_item(OP_TICK, 10'($urandom_range(0, 1023)), 1'b0, '0, '0);
        send_item(OP_REPORT, '0, 1'b0, '0, '0);
        long_haul = 1'b0;

        // Drain
        sample_ch.valid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d sample transactions (%0d reports, one %0d-tick long haul)",
                 items_sent, reports_sent, LONG_TICKS);
        $display("Scored %0d results across %0d register writes, %0d mismatches",
                 results_seen, cfg_writes, fail_count);
        if (fail_count == 0)
        begin
            $display("wind_speed_average_and_gust verification clean");
        end
        else
        begin
            $display("wind_speed_average_and_gust verification failed");
        end
        $finish;
    end

endmodule
